/* hdl/assert_macros.svh */
// assertion helpers, empty when synthesized
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`define ASSERT_ONEHOT0(lbl, clk, rst, v) \
   lbl: assert property (@(posedge clk) disable iff (rst) $onehot0(v)) else $error("lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, a, b)
`define ASSERT_NEXT(lbl, clk, rst, a, b)
`define ASSERT_ONEHOT0(lbl, clk, rst, v)
`endif
`endif

/* hdl/arpl_pkg.sv */
package arpl_pkg;
   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 16;
   localparam int CH_W       = 4;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MEAN_W     = 32;
   localparam int ROOT_STEPS = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;
   localparam logic [LEVEL_W-1:0] Q_ONE = 16'd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MONITOR_ENABLE  = 3'd0,
      CSR_SMOOTHING       = 3'd1,
      CSR_CLIP_THRESHOLD  = 3'd2,
      CSR_IN_COUNT        = 3'd3,
      CSR_OUT_COUNT       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic take;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic mem_read;
      logic mul;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic block_end;
   } status_type;
endpackage

/* hdl/arpl_ctrl.sv */
module arpl_ctrl #(
   parameter int SUM_W = 44
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  arpl_pkg::status_type status,
   output arpl_pkg::cmd_type   cmd
);
   localparam int STEP_W = $clog2(SUM_W + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_SQLD, S_SQRT, S_READ, S_MUL, S_FIN
   } state_type;

   state_type           state_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                rsp_valid_ff;
   logic                out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.take      = req_tvalid && (state_ff == S_IDLE);
      cmd.div_step  = (state_ff == S_DIV);
      cmd.sqrt_load = (state_ff == S_SQLD);
      cmd.sqrt_step = (state_ff == S_SQRT);
      cmd.mem_read  = (state_ff == S_READ);
      cmd.mul       = (state_ff == S_MUL);
      cmd.finish    = (state_ff == S_FIN) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            S_IDLE: begin
               step_ff <= '0;
               if (req_tvalid && status.block_end) state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_SQLD;
               end
            end
            S_SQLD: state_ff <= S_SQRT;
            S_SQRT: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(arpl_pkg::ROOT_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_MUL;
            S_MUL:  state_ff <= S_FIN;
            S_FIN: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* hdl/arpl_datapath.sv */
module arpl_datapath #(
   parameter int CHANNELS      = 16,
   parameter int BLOCK_SAMPLES = 4096,
   parameter int SUM_W         = 44
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [arpl_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [0:0]                          req_tuser,
   input  logic                                req_tlast,
   output logic [arpl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [arpl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arpl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  arpl_pkg::cmd_type                   cmd,
   output arpl_pkg::status_type                status
);
   localparam int DEPTH = 2 * CHANNELS;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(BLOCK_SAMPLES + 1);
   localparam int LW    = arpl_pkg::LEVEL_W;
   localparam logic [LW-1:0] Q_ONE_C = arpl_pkg::Q_ONE;

   // configuration
   logic                          mon_en_ff;
   logic [LW-1:0]                 smooth_ff, clip_thr_ff;
   logic [arpl_pkg::COUNT_W-1:0]  in_cnt_ff, out_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mon_en_ff   <= 1'b1;
         smooth_ff   <= 16'd3277;
         clip_thr_ff <= 16'd32440;
         in_cnt_ff   <= 5'd2;
         out_cnt_ff  <= 5'd2;
      end else if (csr_we) begin
         case (arpl_pkg::csr_index_type'(csr_index))
            arpl_pkg::CSR_MONITOR_ENABLE: mon_en_ff   <= csr_wdata[0];
            arpl_pkg::CSR_SMOOTHING:      smooth_ff   <= csr_wdata;
            arpl_pkg::CSR_CLIP_THRESHOLD: clip_thr_ff <= csr_wdata;
            arpl_pkg::CSR_IN_COUNT:       in_cnt_ff   <= csr_wdata[arpl_pkg::COUNT_W-1:0];
            arpl_pkg::CSR_OUT_COUNT:      out_cnt_ff  <= csr_wdata[arpl_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // request decode
   logic                             op, dir;
   logic [arpl_pkg::CH_W-1:0]        ch;
   logic [arpl_pkg::SAMPLE_W-1:0]    smp;
   logic [arpl_pkg::COUNT_W-1:0]     lim;
   logic                             sample_ok;
   logic [LW-1:0]                    mag;
   logic [31:0]                      sq;

   assign op  = req_tuser[0];
   assign dir = req_tdata[0];
   assign ch  = req_tdata[4:1];
   assign smp = req_tdata[20:5];
   assign lim = dir ? out_cnt_ff : in_cnt_ff;
   assign sample_ok = !op && mon_en_ff && ({1'b0, ch} < lim) && (int'(ch) < CHANNELS);
   assign status.block_end = sample_ok && req_tlast;
   assign mag = smp[15] ? (~smp + 16'd1) : smp;
   assign sq  = 32'(mag) * 32'(mag);

   // block accumulator
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LW-1:0]    peak_ff, peak_in;

   always_comb begin
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      if (int'(cnt_ff) < BLOCK_SAMPLES) begin
         sum_in = sum_ff + SUM_W'(sq);
         cnt_in = cnt_ff + 1'b1;
      end
      peak_in = (mag > peak_ff) ? mag : peak_ff;
   end

   // divider, sqrt and end-of-block registers
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  dvs_ff, rem_ff;
   logic [CNT_W:0]    div_t;
   logic              div_ge;
   logic [LW-1:0]     blk_peak_ff;
   logic              dir_ff;
   logic [arpl_pkg::CH_W-1:0] ch_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic [arpl_pkg::MEAN_W-1:0] sv_ff;
   logic [LW-1:0]     root_ff;
   logic [16:0]       srem_ff;
   logic [18:0]       sq_t, sq_trial;
   logic              sq_ge;

   assign div_t    = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge   = div_t >= {1'b0, dvs_ff};
   assign sq_t     = {srem_ff, sv_ff[31:30]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_t >= sq_trial;

   // per-channel stores
   logic [LW-1:0]     lvl_mem [DEPTH];
   logic [LW-1:0]     hold_mem [DEPTH];
   logic [DEPTH-1:0]  lvl_vld_ff, hold_vld_ff;
   logic [1:0]        clip_ff;
   logic [LW-1:0]     rd_lvl_ff, rd_hold_ff, level_ff, hold_ff;
   logic              lvl_ok_ff, hold_ok_ff;
   logic signed [33:0] prod_ff;

   logic [LW-1:0]        fac;
   logic signed [16:0]   diff;
   logic [LW-1:0]        cur_lvl, cur_hold;
   logic signed [34:0]   pr;
   logic signed [20:0]   r;
   logic [LW-1:0]        new_lvl, new_hold;
   logic                 new_clip;

   always_comb begin
      fac      = (smooth_ff > Q_ONE_C) ? Q_ONE_C : smooth_ff;
      cur_lvl  = lvl_ok_ff ? rd_lvl_ff : '0;
      cur_hold = hold_ok_ff ? rd_hold_ff : '0;
      diff     = $signed({1'b0, root_ff}) - $signed({1'b0, cur_lvl});
      pr       = 35'(prod_ff) + 35'sd16384;
      // flooring shift, rounds half up
      r        = $signed({5'b0, level_ff}) + 21'(pr >>> 15);
      if (r < 0) new_lvl = '0;
      else if (r > 21'sd32768) new_lvl = Q_ONE_C;
      else new_lvl = r[LW-1:0];
      new_hold = (blk_peak_ff > hold_ff) ? blk_peak_ff : hold_ff;
      new_clip = clip_ff[dir_ff] || (blk_peak_ff >= clip_thr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         cnt_ff      <= '0;
         peak_ff     <= '0;
         lvl_vld_ff  <= '0;
         hold_vld_ff <= '0;
         clip_ff     <= '0;
      end else begin
         if (cmd.take && op) begin
            hold_vld_ff <= '0;
            clip_ff     <= '0;
         end
         if (cmd.take && sample_ok) begin
            if (req_tlast) begin
               sum_ff  <= '0;
               cnt_ff  <= '0;
               peak_ff <= '0;
            end else begin
               sum_ff  <= sum_in;
               cnt_ff  <= cnt_in;
               peak_ff <= peak_in;
            end
         end
         if (cmd.finish) begin
            lvl_vld_ff[idx_ff]  <= 1'b1;
            hold_vld_ff[idx_ff] <= 1'b1;
            clip_ff[dir_ff]     <= new_clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && status.block_end) begin
         quo_ff      <= sum_in;
         dvs_ff      <= cnt_in;
         rem_ff      <= '0;
         blk_peak_ff <= peak_in;
         dir_ff      <= dir;
         ch_ff       <= ch;
         idx_ff      <= dir ? (IDX_W'(CHANNELS) + IDX_W'(ch)) : IDX_W'(ch);
      end
      // restoring divide, one quotient bit a cycle
      if (cmd.div_step) begin
         rem_ff <= div_ge ? CNT_W'(div_t - {1'b0, dvs_ff}) : CNT_W'(div_t);
         quo_ff <= {quo_ff[SUM_W-2:0], div_ge};
      end
      if (cmd.sqrt_load) begin
         sv_ff   <= quo_ff[arpl_pkg::MEAN_W-1:0];
         root_ff <= '0;
         srem_ff <= '0;
      end
      // digit-by-digit root, two radicand bits a cycle
      if (cmd.sqrt_step) begin
         sv_ff   <= {sv_ff[29:0], 2'b00};
         srem_ff <= sq_ge ? 17'(sq_t - sq_trial) : 17'(sq_t);
         root_ff <= {root_ff[LW-2:0], sq_ge};
      end
      if (cmd.mem_read) begin
         rd_lvl_ff  <= lvl_mem[idx_ff];
         rd_hold_ff <= hold_mem[idx_ff];
         lvl_ok_ff  <= lvl_vld_ff[idx_ff];
         hold_ok_ff <= hold_vld_ff[idx_ff];
      end
      if (cmd.mul) begin
         prod_ff  <= 34'($signed({1'b0, fac})) * 34'(diff);
         level_ff <= cur_lvl;
         hold_ff  <= cur_hold;
      end
      if (cmd.finish) begin
         lvl_mem[idx_ff]  <= new_lvl;
         hold_mem[idx_ff] <= new_hold;
         rsp_tdata <= {2'b00, new_clip, blk_peak_ff, new_hold, new_lvl, ch_ff, dir_ff};
      end
   end
endmodule

/* hdl/audio_rms_peak_level_meter.sv */
// samples are taken one per cycle while the meter is idle; a block-ending sample starts
// the bit-serial divider over SUM_W quotient bits (SUM_W = 31 + clog2(BLOCK_SAMPLES + 1),
// 44 by default), then the 16-step square root, the memory read, the multiply and finish
// the result is registered in the finish state once the output is free
// no request is taken until then; the result waits in an output register
// synchronous active-high reset restores register defaults and zeroes all levels
module audio_rms_peak_level_meter #(
   parameter int CHANNELS      = 16,
   parameter int BLOCK_SAMPLES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // direction, channel[3:0], sample[15:0], zero pad
   input  logic [0:0]  req_tuser,  // op
   input  logic        req_tlast,  // block_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // out_direction, out_channel[3:0], smoothed_rms,
                                   // held_peak, block_peak, clipping, zero pad
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
`include "assert_macros.svh"
   localparam int SUM_W = 31 + $clog2(BLOCK_SAMPLES + 1);

   arpl_pkg::cmd_type    cmd;
   arpl_pkg::status_type status;

   arpl_ctrl #(.SUM_W(SUM_W)) u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .status, .cmd
   );

   arpl_datapath #(
      .CHANNELS(CHANNELS), .BLOCK_SAMPLES(BLOCK_SAMPLES), .SUM_W(SUM_W)
   ) u_dp (
      .clock, .reset, .req_tdata, .req_tuser, .req_tlast, .rsp_tdata,
      .csr_we, .csr_index, .csr_wdata, .cmd, .status
   );

   `ASSERT_ONEHOT0(a_one_phase, clock, reset, {cmd.div_step, cmd.sqrt_step, cmd.mem_read, cmd.mul})
   `ASSERT_IMPLIES(a_busy_no_take, clock, reset, cmd.div_step || cmd.sqrt_step || cmd.mul, !req_tready)
   `ASSERT_NEXT(a_end_starts_div, clock, reset, cmd.take && status.block_end, cmd.div_step)
   `ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_tvalid)
endmodule

/* dv/tb_audio_rms_peak_level_meter.sv */
`timescale 1ns / 1ps

module tb_audio_rms_peak_level_meter;
   localparam int NCH        = 16;
   localparam int MAX_COUNT  = 4096;
   localparam int BLOCK_WAIT = 100;
   localparam int LIMIT      = 600000;

   typedef enum logic {OP_SAMPLE = 1'b0, OP_CLEAR = 1'b1} op_type;

   typedef struct packed {
      logic        dir;
      logic [3:0]  ch;
      logic [15:0] rms;
      logic [15:0] held;
      logic [15:0] peak;
      logic        clip;
   } level_report_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   audio_rms_peak_level_meter dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // meter state mirror
   logic        mon_en;
   logic [15:0] smooth_f, clip_thr;
   logic [4:0]  in_count, out_count;
   logic [63:0] sq_sum;
   int unsigned acc_count;
   logic [16:0] run_peak;
   logic [16:0] level_mem [2*NCH];
   logic [16:0] hold_mem [2*NCH];
   logic        clip_dir [2];

   level_report_type pending_reports[$];
   int errors = 0;
   int cycles = 0;
   int burst_left = 0;
   bit no_gaps = 0;
   bit rsp_stall_on = 1;

   function automatic logic [16:0] floor_sqrt(logic [63:0] v);
      logic [63:0] r;
      r = 0;
      for (int b = 16; b >= 0; b--)
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
      return r[16:0];
   endfunction

   function automatic logic [16:0] smooth_level(logic [16:0] lvl, logic [16:0] rms);
      longint f, p, r;
      f = (smooth_f > 16'd32768) ? 32768 : longint'(smooth_f);
      p = f * (longint'(rms) - longint'(lvl)) + 16384;
      r = longint'(lvl) + (p >>> 15);
      if (r < 0) r = 0;
      if (r > 32768) r = 32768;
      return r[16:0];
   endfunction

   task automatic meter_predict(op_type op, logic dir, logic [3:0] ch, logic [15:0] smp,
                                logic last);
      logic [4:0]  lim;
      logic [16:0] mag, rms;
      int          idx;
      level_report_type rep;
      lim = dir ? out_count : in_count;
      if (lim > NCH) lim = NCH;
      if (op == OP_CLEAR) begin
         foreach (hold_mem[i]) hold_mem[i] = 0;
         clip_dir[0] = 0;
         clip_dir[1] = 0;
         return;
      end
      if (!mon_en || ch >= lim) return;
      mag = smp[15] ? 17'd65536 - smp : {1'b0, smp};
      if (acc_count < MAX_COUNT) begin
         sq_sum += mag * mag;
         acc_count++;
      end
      if (mag > run_peak) run_peak = mag;
      if (!last) return;
      idx = dir * NCH + ch;
      rms = floor_sqrt(sq_sum / (acc_count ? acc_count : 1));
      if (rms > 32768) rms = 32768;
      level_mem[idx] = smooth_level(level_mem[idx], rms);
      if (run_peak > hold_mem[idx]) hold_mem[idx] = run_peak;
      if (run_peak >= clip_thr) clip_dir[dir] = 1;
      rep.dir = dir;
      rep.ch = ch;
      rep.rms = level_mem[idx][15:0];
      rep.held = hold_mem[idx][15:0];
      rep.peak = run_peak[15:0];
      rep.clip = clip_dir[dir];
      pending_reports.insert(pending_reports.size(), rep);
      sq_sum = 0;
      acc_count = 0;
      run_peak = 0;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_request(op_type op, logic dir, logic [3:0] ch, logic [15:0] smp,
                               logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (!no_gaps) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {3'b0, smp, ch, dir};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      meter_predict(op, dir, ch, smp, last);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      burst_left = 0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (BLOCK_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(arpl_pkg::csr_index_type idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         arpl_pkg::CSR_MONITOR_ENABLE: mon_en = val[0];
         arpl_pkg::CSR_SMOOTHING:      smooth_f = val;
         arpl_pkg::CSR_CLIP_THRESHOLD: clip_thr = val;
         arpl_pkg::CSR_IN_COUNT:       in_count = val[4:0];
         arpl_pkg::CSR_OUT_COUNT:      out_count = val[4:0];
         default: ;
      endcase
   endtask

   task automatic send_block(logic dir, logic [3:0] ch, int len);
      for (int i = 0; i < len; i++)
         send_request(OP_SAMPLE, dir, ch, 16'($urandom), i == len - 1);
   endtask

   task automatic test_extremes();
      send_request(OP_SAMPLE, 0, 0, 16'h8000, 1);
      send_request(OP_SAMPLE, 1, 1, 16'h7fff, 1);
      send_request(OP_SAMPLE, 0, 1, 16'h0000, 1);
      send_request(OP_SAMPLE, 1, 0, 16'hffff, 0);
      send_request(OP_SAMPLE, 1, 0, 16'h0001, 1);
      send_request(OP_CLEAR, 1, 4'hf, 16'hffff, 1);
      send_request(OP_SAMPLE, 0, 0, 16'h1234, 1);
      // mixed channels share one accumulator
      send_request(OP_SAMPLE, 0, 0, 16'h4000, 0);
      send_request(OP_SAMPLE, 1, 1, 16'hc000, 1);
      // out of range channel, even when marked
      send_request(OP_SAMPLE, 0, 4'hf, 16'h7fff, 1);
      send_request(OP_SAMPLE, 1, 2, 16'h7fff, 1);
      send_request(OP_SAMPLE, 0, 1, 16'h0100, 1);
      drain();
   endtask

   task automatic test_monitor_off();
      csr_write(arpl_pkg::CSR_MONITOR_ENABLE, 16'd0);
      send_request(OP_SAMPLE, 0, 0, 16'h7fff, 0);
      send_request(OP_SAMPLE, 0, 0, 16'h7fff, 1);
      send_request(OP_CLEAR, 0, 0, 16'h0, 0);
      drain();
      csr_write(arpl_pkg::CSR_MONITOR_ENABLE, 16'd1);
      send_request(OP_SAMPLE, 0, 0, 16'h0200, 1);
      drain();
   endtask

   task automatic test_random_phase(int n_items, logic [15:0] sf, logic [15:0] thr,
                                    logic [4:0] ic, logic [4:0] oc);
      int sent;
      csr_write(arpl_pkg::CSR_SMOOTHING, sf);
      csr_write(arpl_pkg::CSR_CLIP_THRESHOLD, thr);
      csr_write(arpl_pkg::CSR_IN_COUNT, ic);
      csr_write(arpl_pkg::CSR_OUT_COUNT, oc);
      sent = 0;
      while (sent < n_items) begin
         int pick;
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_request(OP_CLEAR, 1'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 3) begin
            send_request(OP_SAMPLE, 1'($urandom), 4'($urandom), 16'($urandom),
                         1'($urandom));
            sent++;
         end else begin
            logic       d;
            logic [4:0] lim;
            int         len;
            d = 1'($urandom);
            lim = d ? oc : ic;
            if (lim > NCH) lim = NCH;
            len = $urandom_range(1, 12);
            send_block(d, (lim == 0) ? 4'($urandom) : 4'($urandom_range(0, lim - 1)), len);
            sent += len;
         end
      end
      drain();
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles % 997 == 0) rsp_stall_on <= ~rsp_stall_on;
      rsp_tready <= !rsp_stall_on || ((cycles % 7 != 3) && $urandom_range(0, 3) != 0);
      if (cycles > LIMIT) begin
         $display("audio_rms_peak_level_meter test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         level_report_type got, want;
         got = rsp_tdata[53:0];
         got.dir = rsp_tdata[0];
         got.ch = rsp_tdata[4:1];
         got.rms = rsp_tdata[20:5];
         got.held = rsp_tdata[36:21];
         got.peak = rsp_tdata[52:37];
         got.clip = rsp_tdata[53];
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected level report", 1, 0);
         end else begin
            want = pending_reports.pop_front();
            if (got.dir != want.dir) report_mismatch("out_direction", got.dir, want.dir);
            if (got.ch != want.ch) report_mismatch("out_channel", got.ch, want.ch);
            if (got.rms != want.rms) report_mismatch("smoothed_rms", got.rms, want.rms);
            if (got.held != want.held) report_mismatch("held_peak", got.held, want.held);
            if (got.peak != want.peak) report_mismatch("block_peak", got.peak, want.peak);
            if (got.clip != want.clip) report_mismatch("clipping", got.clip, want.clip);
         end
      end
   end

   initial begin
      mon_en = 1;
      smooth_f = 16'd3277;
      clip_thr = 16'd32440;
      in_count = 5'd2;
      out_count = 5'd2;
      sq_sum = 0;
      acc_count = 0;
      run_peak = 0;
      foreach (level_mem[i]) begin
         level_mem[i] = 0;
         hold_mem[i] = 0;
      end
      clip_dir[0] = 0;
      clip_dir[1] = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_extremes();
      test_monitor_off();
      test_random_phase(250, 16'd3277, 16'd32440, 5'd16, 5'd16);
      no_gaps = 1;
      test_random_phase(200, 16'd0, 16'd0, 5'd31, 5'd0);
      no_gaps = 0;
      test_random_phase(200, 16'hffff, 16'hffff, 5'd5, 5'd17);
      test_random_phase(200, 16'd32768, 16'd32768, 5'd0, 5'd9);
      test_random_phase(200, 16'($urandom), 16'd16384, 5'd16, 5'd16);
      if (errors == 0 && pending_reports.size() == 0)
         $display("audio_rms_peak_level_meter test passed");
      else
         $display("audio_rms_peak_level_meter test failed");
      $finish;
   end
endmodule
